// ===== src/wgs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and register codes of the wind grid sampler.
package wgs_pkg;

   localparam int VEL_W     = 32;
   localparam int LANES     = 3;
   localparam int FRAC_W    = 16;
   localparam int SPEED_W   = 31;
   localparam int CSR_IDX_W = 3;
   localparam int NUM_W     = 62;
   localparam int ROOT_W    = 32;
   localparam int RAD_W     = 64;

   localparam logic [VEL_W-1:0]   INV_CELL_RESET  = 32'h0001_0000;
   localparam logic [SPEED_W-1:0] MAX_SPEED_RESET = 31'd65536000;

   typedef logic signed [VEL_W-1:0]    vel_type;
   typedef logic [LANES-1:0][VEL_W-1:0] cell_type;
   typedef logic [NUM_W-1:0]           num_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_X  = 3'd0,
      CSR_CENTER_Y  = 3'd1,
      CSR_CENTER_Z  = 3'd2,
      CSR_INV_CELL  = 3'd3,
      CSR_MAX_SPEED = 3'd4
   } csr_reg_type;

endpackage

// ===== src/wgs_cell_ram.sv =====
`timescale 1ns / 1ps
// Velocity cell memory: one write port, one registered read port.
module wgs_cell_ram #(
   parameter int DEPTH  = 32768,
   parameter int ADDR_W = 15
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  wgs_pkg::cell_type     wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_addr,
   output wgs_pkg::cell_type     rd_data
);
   import wgs_pkg::*;

   cell_type mem [DEPTH];
   cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/wgs_isqrt.sv =====
`timescale 1ns / 1ps
// Integer square root of a 64-bit value, two radicand bits per cycle.
module wgs_isqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [wgs_pkg::RAD_W-1:0]   radicand,
   output logic                        done,
   output logic [wgs_pkg::ROOT_W-1:0]  root
);
   import wgs_pkg::*;

   logic [RAD_W-1:0] rem_ff, rem_in;
   logic [RAD_W-1:0] res_ff, res_in;
   logic [RAD_W-1:0] bit_ff, bit_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [RAD_W-1:0] trial;

   assign trial = res_ff + bit_ff;

   always_comb begin
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = radicand;
         res_in = '0;
         bit_in = {2'b01, {(RAD_W-2){1'b0}}};
         run_in = 1'b1;
      end else if (run_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         // last radicand pair consumed
         if (bit_ff[0]) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[ROOT_W-1:0];

endmodule

// ===== src/wgs_div.sv =====
`timescale 1ns / 1ps
// Three-lane restoring divider, one quotient bit per lane per cycle.
module wgs_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  wgs_pkg::num_type            num [wgs_pkg::LANES],
   input  logic [wgs_pkg::ROOT_W-1:0]  den,
   output logic                        done,
   output logic [wgs_pkg::ROOT_W-1:0]  quo [wgs_pkg::LANES]
);
   import wgs_pkg::*;

   localparam int CNT_W = $clog2(ROOT_W);

   logic [ROOT_W-1:0] rem_ff [LANES];
   logic [ROOT_W-1:0] rem_in [LANES];
   logic [ROOT_W-1:0] nq_ff  [LANES];
   logic [ROOT_W-1:0] nq_in  [LANES];
   logic [ROOT_W:0]   part   [LANES];
   logic [ROOT_W-1:0] den_ff;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;

   always_comb begin
      run_in  = run_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      for (int c = 0; c < LANES; c++) begin
         rem_in[c] = rem_ff[c];
         nq_in[c]  = nq_ff[c];
         part[c]   = {rem_ff[c], nq_ff[c][ROOT_W-1]};
      end
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         // quotient stays below 2^32, so the top part starts below the divisor
         for (int c = 0; c < LANES; c++) begin
            rem_in[c] = ROOT_W'(num[c][NUM_W-1:ROOT_W]);
            nq_in[c]  = num[c][ROOT_W-1:0];
         end
      end else if (run_ff) begin
         for (int c = 0; c < LANES; c++) begin
            if (part[c] >= {1'b0, den_ff}) begin
               rem_in[c] = ROOT_W'(part[c] - {1'b0, den_ff});
               nq_in[c]  = {nq_ff[c][ROOT_W-2:0], 1'b1};
            end else begin
               rem_in[c] = part[c][ROOT_W-1:0];
               nq_in[c]  = {nq_ff[c][ROOT_W-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ROOT_W-1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= den;
      end
      for (int c = 0; c < LANES; c++) begin
         rem_ff[c] <= rem_in[c];
         nq_ff[c]  <= nq_in[c];
      end
   end

   assign done = done_ff;
   always_comb begin
      for (int c = 0; c < LANES; c++) begin
         quo[c] = nq_ff[c];
      end
   end

endmodule

// ===== src/wind_grid_sample_and_inject.sv =====
`timescale 1ns / 1ps
// Wind grid: trilinear sample and clamped velocity inject on a cubic cell memory.
// Sample: map, cell reads and 7 lerp steps from accept to rsp_valid. An add inside the grid
//   reads, sums, checks and writes the cell, with the 32-step square root and the 32-step
//   divider when the speed clamp runs; an add outside the grid responds after the map.
// Throughput: one transaction at a time; the cell memory's single read port and the
//   clamp units set the rate. A new start is taken in the cycle rsp_valid is shown.
// Reset: after reset, busy stays high while the memory is cleared.
// rsp_valid is a one-cycle strobe; the receiver cannot stall it.
module wind_grid_sample_and_inject #(
   parameter int GRID_EDGE = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_cmd,
   input  wgs_pkg::vel_type                 req_loc_x,
   input  wgs_pkg::vel_type                 req_loc_y,
   input  wgs_pkg::vel_type                 req_loc_z,
   input  wgs_pkg::vel_type                 req_add_vx,
   input  wgs_pkg::vel_type                 req_add_vy,
   input  wgs_pkg::vel_type                 req_add_vz,
   output logic                             rsp_valid,
   output wgs_pkg::vel_type                 rsp_vel_x,
   output wgs_pkg::vel_type                 rsp_vel_y,
   output wgs_pkg::vel_type                 rsp_vel_z,
   output logic                             rsp_status,
   input  logic                             csr_we,
   input  logic [wgs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [wgs_pkg::VEL_W-1:0]        csr_wdata
);
   import wgs_pkg::*;

   localparam int IDX_W   = $clog2(GRID_EDGE);
   localparam int EDGE_SQ = GRID_EDGE * GRID_EDGE;
   localparam int DEPTH   = EDGE_SQ * GRID_EDGE;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int QDEPTH  = 8;

   typedef struct packed {
      logic              v0;
      logic [IDX_W-1:0]  i0;
      logic              v1;
      logic [IDX_W-1:0]  i1;
      logic [FRAC_W-1:0] frac;
   } axis_type;

   typedef enum logic [15:0] {
      S_CLEAR    = 16'h0001,
      S_IDLE     = 16'h0002,
      S_MAP      = 16'h0004,
      S_READ     = 16'h0008,
      S_LERP     = 16'h0010,
      S_ADD_RD   = 16'h0020,
      S_ADD_SUM  = 16'h0040,
      S_ADD_MAG  = 16'h0080,
      S_ADD_SQ   = 16'h0100,
      S_ADD_TOT  = 16'h0200,
      S_ADD_CMP  = 16'h0400,
      S_SQRT     = 16'h0800,
      S_DIV_PRE  = 16'h1000,
      S_DIV_GO   = 16'h2000,
      S_DIV      = 16'h4000,
      S_WRITE    = 16'h8000
   } state_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] ix,
                                                   input logic [IDX_W-1:0] iy,
                                                   input logic [IDX_W-1:0] iz);
      cell_addr = ADDR_W'(ix) + ADDR_W'(iy) * ADDR_W'(GRID_EDGE)
                + ADDR_W'(iz) * ADDR_W'(EDGE_SQ);
   endfunction

   // ---------------------------------------------------------------- registers
   state_type          state_ff, state_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;

   vel_type            cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic [VEL_W-1:0]   inv_ff, inv_in;
   logic [SPEED_W-1:0] max_ff, max_in;

   logic               cmd_ff, cmd_in;
   logic signed [32:0] local_ff [LANES];
   logic signed [32:0] local_in [LANES];
   vel_type            addv_ff  [LANES];
   vel_type            addv_in  [LANES];
   logic signed [65:0] prod_ff, prod_in;
   axis_type           ax_ff [LANES];
   axis_type           ax_in [LANES];

   logic               rd_pend_ff, rd_pend_in;
   logic               rd_cv_ff, rd_cv_in;
   cell_type           q_ff [QDEPTH];
   cell_type           q_in [QDEPTH];

   logic signed [32:0] sum_ff [LANES];
   logic signed [32:0] sum_in [LANES];
   logic [SPEED_W-1:0] msh_ff [LANES];
   logic [SPEED_W-1:0] msh_in [LANES];
   logic               anygt_ff, anygt_in;
   num_type            sq_ff [LANES];
   num_type            sq_in [LANES];
   num_type            ms2_ff, ms2_in;
   logic [RAD_W-1:0]   s_ff, s_in;
   logic               over_ff, over_in;
   num_type            num_ff [LANES];
   num_type            num_in [LANES];
   logic [ROOT_W-1:0]  den_ff, den_in;

   logic               rsp_valid_ff, rsp_valid_in;
   cell_type           rsp_vel_ff, rsp_vel_in;
   logic               rsp_status_ff, rsp_status_in;

   // ---------------------------------------------------------------- datapath wires
   logic                ram_we, ram_re;
   logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
   cell_type            ram_wdata, ram_rdata;

   logic                sqrt_start, sqrt_done;
   logic [ROOT_W-1:0]   sqrt_root;
   logic                div_start, div_done;
   logic [ROOT_W-1:0]   div_quo [LANES];

   logic signed [65:0]  map_prod;
   logic signed [33:0]  pidx;
   logic signed [34:0]  pidx1;
   axis_type            new_ax;

   logic [ADDR_W-1:0]   addr0, addr_n;
   logic                cell_ok_n;
   cell_type            rd_val;

   logic [FRAC_W-1:0]   lfrac;
   logic signed [32:0]  ldiff [LANES];
   logic signed [49:0]  lprod [LANES];
   cell_type            lres;

   logic [32:0]         mag_w [LANES];
   logic                over_w;
   cell_type            wval;

   // Map local coordinate to cell index and fraction. Floor of a signed Q.32
   // product is the arithmetic shift, so both signs share one path.
   assign map_prod = local_ff[0] * $signed({1'b0, inv_ff});
   assign pidx     = prod_ff[65:32];
   assign pidx1    = {pidx[33], pidx} + 35'sd1;

   always_comb begin
      new_ax.v0   = !pidx[33] && (pidx < $signed(34'(GRID_EDGE)));
      new_ax.i0   = pidx[IDX_W-1:0];
      // upper neighbor is clamped to the last cell; it is inside whenever idx >= -1
      new_ax.v1   = !pidx1[34];
      new_ax.i1   = (pidx1 < $signed(35'(GRID_EDGE - 1))) ? pidx1[IDX_W-1:0]
                                                          : IDX_W'(GRID_EDGE - 1);
      new_ax.frac = prod_ff[31:16];
   end

   // Neighbor n: bit 0 picks upper x, bit 1 upper y, bit 2 upper z.
   assign addr0     = cell_addr(ax_ff[0].i0, ax_ff[1].i0, ax_ff[2].i0);
   assign addr_n    = cell_addr(cnt_ff[0] ? ax_ff[0].i1 : ax_ff[0].i0,
                                cnt_ff[1] ? ax_ff[1].i1 : ax_ff[1].i0,
                                cnt_ff[2] ? ax_ff[2].i1 : ax_ff[2].i0);
   assign cell_ok_n = (cnt_ff[0] ? ax_ff[0].v1 : ax_ff[0].v0)
                    & (cnt_ff[1] ? ax_ff[1].v1 : ax_ff[1].v0)
                    & (cnt_ff[2] ? ax_ff[2].v1 : ax_ff[2].v0);
   assign rd_val    = rd_cv_ff ? ram_rdata : '0;

   // Lerp lanes: x over steps 0-3, y over 4-5, z at step 6.
   always_comb begin
      if (cnt_ff < 4'd4) begin
         lfrac = ax_ff[0].frac;
      end else if (cnt_ff < 4'd6) begin
         lfrac = ax_ff[1].frac;
      end else begin
         lfrac = ax_ff[2].frac;
      end
      for (int c = 0; c < LANES; c++) begin
         ldiff[c] = $signed({q_ff[1][c][VEL_W-1], q_ff[1][c]})
                  - $signed({q_ff[0][c][VEL_W-1], q_ff[0][c]});
         lprod[c] = ldiff[c] * $signed({1'b0, lfrac});
         lres[c]  = q_ff[0][c] + lprod[c][47:16];
      end
   end

   // Add path helpers
   always_comb begin
      for (int c = 0; c < LANES; c++) begin
         mag_w[c] = sum_ff[c][32] ? 33'(-sum_ff[c]) : 33'(sum_ff[c]);
         if (over_ff) begin
            wval[c] = sum_ff[c][32] ? (VEL_W'(0) - div_quo[c]) : div_quo[c];
         end else begin
            wval[c] = sum_ff[c][VEL_W-1:0];
         end
      end
   end
   assign over_w = anygt_ff || (s_ff > RAD_W'(ms2_ff));

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      clr_in        = clr_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      cz_in         = cz_ff;
      inv_in        = inv_ff;
      max_in        = max_ff;
      cmd_in        = cmd_ff;
      prod_in       = prod_ff;
      rd_pend_in    = 1'b0;
      rd_cv_in      = rd_cv_ff;
      anygt_in      = anygt_ff;
      ms2_in        = ms2_ff;
      s_in          = s_ff;
      over_in       = over_ff;
      den_in        = den_ff;
      rsp_valid_in  = 1'b0;
      rsp_vel_in    = rsp_vel_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_waddr     = addr0;
      ram_wdata     = wval;
      ram_re        = 1'b0;
      ram_raddr     = addr_n;
      sqrt_start    = 1'b0;
      div_start     = 1'b0;
      for (int c = 0; c < LANES; c++) begin
         local_in[c] = local_ff[c];
         addv_in[c]  = addv_ff[c];
         ax_in[c]    = ax_ff[c];
         sum_in[c]   = sum_ff[c];
         msh_in[c]   = msh_ff[c];
         sq_in[c]    = sq_ff[c];
         num_in[c]   = num_ff[c];
      end
      for (int i = 0; i < QDEPTH; i++) begin
         q_in[i] = q_ff[i];
      end

      if (csr_we) begin
         case (csr_index)
            CSR_CENTER_X:  cx_in  = csr_wdata;
            CSR_CENTER_Y:  cy_in  = csr_wdata;
            CSR_CENTER_Z:  cz_in  = csr_wdata;
            CSR_INV_CELL:  inv_in = csr_wdata;
            CSR_MAX_SPEED: max_in = csr_wdata[SPEED_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            // sweep zeros through the memory, one entry a cycle
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd_in      = req_cmd;
               local_in[0] = {req_loc_x[VEL_W-1], req_loc_x} - {cx_ff[VEL_W-1], cx_ff};
               local_in[1] = {req_loc_y[VEL_W-1], req_loc_y} - {cy_ff[VEL_W-1], cy_ff};
               local_in[2] = {req_loc_z[VEL_W-1], req_loc_z} - {cz_ff[VEL_W-1], cz_ff};
               addv_in[0]  = req_add_vx;
               addv_in[1]  = req_add_vy;
               addv_in[2]  = req_add_vz;
               cnt_in      = '0;
               state_in    = S_MAP;
            end
         end
         S_MAP: begin
            // one axis through the multiplier a cycle, convert it the next
            prod_in     = map_prod;
            local_in[0] = local_ff[1];
            local_in[1] = local_ff[2];
            if (cnt_ff != 4'd0) begin
               ax_in[0] = ax_ff[1];
               ax_in[1] = ax_ff[2];
               ax_in[2] = new_ax;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 4'd3) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (cnt_ff == 4'd4) begin
               ax_in[0] = ax_ff[0];
               ax_in[1] = ax_ff[1];
               ax_in[2] = ax_ff[2];
               cnt_in   = '0;
               if (!cmd_ff) begin
                  state_in = S_READ;
               end else if (ax_ff[0].v0 && ax_ff[1].v0 && ax_ff[2].v0) begin
                  state_in = S_ADD_RD;
               end else begin
                  // add outside the grid: drop the write, report status
                  rsp_valid_in  = 1'b1;
                  rsp_vel_in    = '0;
                  rsp_status_in = 1'b1;
                  state_in      = S_IDLE;
               end
            end
         end
         S_READ: begin
            if (cnt_ff < 4'd8) begin
               ram_re     = 1'b1;
               ram_raddr  = addr_n;
               rd_pend_in = 1'b1;
               rd_cv_in   = cell_ok_n;
            end
            if (rd_pend_ff) begin
               for (int i = 0; i < QDEPTH - 1; i++) begin
                  q_in[i] = q_ff[i+1];
               end
               q_in[QDEPTH-1] = rd_val;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 4'd8) begin
               cnt_in   = '0;
               state_in = S_LERP;
            end
         end
         S_LERP: begin
            // consume the two oldest values, append the lerp behind the rest
            for (int i = 0; i < QDEPTH; i++) begin
               if (3'(i) == (3'd6 - cnt_ff[2:0])) begin
                  q_in[i] = lres;
               end else if (i + 2 < QDEPTH) begin
                  q_in[i] = q_ff[i+2];
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 4'd6) begin
               rsp_valid_in  = 1'b1;
               rsp_vel_in    = lres;
               rsp_status_in = 1'b0;
               cnt_in        = '0;
               state_in      = S_IDLE;
            end
         end
         S_ADD_RD: begin
            ram_re    = 1'b1;
            ram_raddr = addr0;
            state_in  = S_ADD_SUM;
         end
         S_ADD_SUM: begin
            for (int c = 0; c < LANES; c++) begin
               sum_in[c] = $signed({ram_rdata[c][VEL_W-1], ram_rdata[c]})
                         + $signed({addv_ff[c][VEL_W-1], addv_ff[c]});
            end
            state_in = S_ADD_MAG;
         end
         S_ADD_MAG: begin
            // any magnitude at or above 2^31 drops two bits on all lanes
            anygt_in = 1'b0;
            for (int c = 0; c < LANES; c++) begin
               if (mag_w[c] > {2'b00, max_ff}) begin
                  anygt_in = 1'b1;
               end
            end
            for (int c = 0; c < LANES; c++) begin
               if ((|mag_w[0][32:31]) || (|mag_w[1][32:31]) || (|mag_w[2][32:31])) begin
                  msh_in[c] = mag_w[c][32:2];
               end else begin
                  msh_in[c] = mag_w[c][SPEED_W-1:0];
               end
            end
            state_in = S_ADD_SQ;
         end
         S_ADD_SQ: begin
            for (int c = 0; c < LANES; c++) begin
               sq_in[c] = NUM_W'(msh_ff[c]) * NUM_W'(msh_ff[c]);
            end
            ms2_in   = NUM_W'(max_ff) * NUM_W'(max_ff);
            state_in = S_ADD_TOT;
         end
         S_ADD_TOT: begin
            s_in     = RAD_W'(sq_ff[0]) + RAD_W'(sq_ff[1]) + RAD_W'(sq_ff[2]);
            state_in = S_ADD_CMP;
         end
         S_ADD_CMP: begin
            over_in = over_w;
            if (over_w) begin
               sqrt_start = 1'b1;
               state_in   = S_SQRT;
            end else begin
               state_in = S_WRITE;
            end
         end
         S_SQRT: begin
            if (sqrt_done) begin
               state_in = S_DIV_PRE;
            end
         end
         S_DIV_PRE: begin
            for (int c = 0; c < LANES; c++) begin
               num_in[c] = NUM_W'(msh_ff[c]) * NUM_W'(max_ff);
            end
            den_in   = (sqrt_root == '0) ? ROOT_W'(1) : sqrt_root;
            state_in = S_DIV_GO;
         end
         S_DIV_GO: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            ram_we        = 1'b1;
            ram_waddr     = addr0;
            ram_wdata     = wval;
            rsp_valid_in  = 1'b1;
            rsp_vel_in    = wval;
            rsp_status_in = 1'b0;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         clr_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cx_ff        <= '0;
         cy_ff        <= '0;
         cz_ff        <= '0;
         inv_ff       <= INV_CELL_RESET;
         max_ff       <= MAX_SPEED_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         clr_ff       <= clr_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         cx_ff        <= cx_in;
         cy_ff        <= cy_in;
         cz_ff        <= cz_in;
         inv_ff       <= inv_in;
         max_ff       <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      prod_ff       <= prod_in;
      rd_cv_ff      <= rd_cv_in;
      anygt_ff      <= anygt_in;
      ms2_ff        <= ms2_in;
      s_ff          <= s_in;
      over_ff       <= over_in;
      den_ff        <= den_in;
      rsp_vel_ff    <= rsp_vel_in;
      rsp_status_ff <= rsp_status_in;
      for (int c = 0; c < LANES; c++) begin
         local_ff[c] <= local_in[c];
         addv_ff[c]  <= addv_in[c];
         ax_ff[c]    <= ax_in[c];
         sum_ff[c]   <= sum_in[c];
         msh_ff[c]   <= msh_in[c];
         sq_ff[c]    <= sq_in[c];
         num_ff[c]   <= num_in[c];
      end
      for (int i = 0; i < QDEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   // ---------------------------------------------------------------- units
   wgs_cell_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   wgs_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (s_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   wgs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (den_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   // ---------------------------------------------------------------- ports
   assign busy       = reset | (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_vel_x  = rsp_vel_ff[0];
   assign rsp_vel_y  = rsp_vel_ff[1];
   assign rsp_vel_z  = rsp_vel_ff[2];
   assign rsp_status = rsp_status_ff;

   // ---------------------------------------------------------------- checks
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted transaction did not hold the block busy");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |->
         (rsp_vel_x == '0 && rsp_vel_y == '0 && rsp_vel_z == '0))
      else $error("outside add returned a nonzero velocity");

   a_sqrt_owner: assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> (state_ff == S_SQRT))
      else $error("square root finished outside its wait state");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the wind grid sampler: directed and random transactions.
module testbench;
   import wgs_pkg::*;

   localparam int  EDGE        = 32;
   localparam int  NCELL       = EDGE * EDGE * EDGE;
   localparam bit  CMD_SAMPLE  = 1'b0;
   localparam bit  CMD_ADD     = 1'b1;
   localparam bit  ST_OK       = 1'b0;
   localparam bit  ST_OUTSIDE  = 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int  PHASES      = 6;
   localparam int  RAND_ITEMS  = 330;
   localparam int  SETTLE      = 120;

   typedef struct packed {
      bit          cmd;
      logic [31:0] lx, ly, lz;
      logic [31:0] vx, vy, vz;
   } wind_req_type;

   typedef struct packed {
      logic [31:0] vx, vy, vz;
      bit          st;
   } wind_rsp_type;

   // Scoreboard: own copy of the grid and registers, plus the queue of expected responses.
   class wind_scoreboard;
      int           cell_x[NCELL];
      int           cell_y[NCELL];
      int           cell_z[NCELL];
      longint       ctr[3];
      bit [63:0]    inv_scale;
      bit [63:0]    speed_cap;
      wind_rsp_type pending_rsp[$];
      int           errors;

      function new();
         foreach (cell_x[i]) begin
            cell_x[i] = 0; cell_y[i] = 0; cell_z[i] = 0;
         end
         ctr = '{0, 0, 0};
         inv_scale = 64'd65536;
         speed_cap = 64'd65536000;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
         case (idx)
            CSR_CENTER_X:  ctr[0] = longint'(signed'(val));
            CSR_CENTER_Y:  ctr[1] = longint'(signed'(val));
            CSR_CENTER_Z:  ctr[2] = longint'(signed'(val));
            CSR_INV_CELL:  inv_scale = {32'd0, val};
            CSR_MAX_SPEED: speed_cap = {33'd0, val[30:0]};
            default: ;
         endcase
      endfunction

      function void to_grid(longint offs, output longint idx, output longint frac);
         bit [63:0] mag, m, q, r;
         mag = (offs < 0) ? 64'(-offs) : 64'(offs);
         m = mag * inv_scale;
         if (offs >= 0) begin
            q = m >> 16;
            idx = longint'(q >> 16);
            frac = longint'(q & 64'hFFFF);
         end else begin
            q = (m + 64'hFFFF) >> 16;
            r = q & 64'hFFFF;
            idx = -longint'((q + 64'hFFFF) >> 16);
            frac = (r != 0) ? longint'(64'd65536 - r) : 0;
         end
      endfunction

      function longint floor16(longint v);
         if (v >= 0) return longint'(64'(v) >> 16);
         return -longint'((64'(-v) + 64'hFFFF) >> 16);
      endfunction

      function longint blend(longint a, longint b, longint f);
         return a + floor16((b - a) * f);
      endfunction

      function bit on_grid(longint x, longint y, longint z);
         return x >= 0 && x < EDGE && y >= 0 && y < EDGE && z >= 0 && z < EDGE;
      endfunction

      function longint fetch(int lane, longint x, longint y, longint z);
         int a;
         if (!on_grid(x, y, z)) return 0;
         a = int'(x + y * EDGE + z * EDGE * EDGE);
         if (lane == 0) return cell_x[a];
         if (lane == 1) return cell_y[a];
         return cell_z[a];
      endfunction

      function bit [63:0] root64(bit [63:0] v);
         bit [63:0] res, b;
         res = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= res + b) begin
               v -= res + b;
               res = (res >> 1) + b;
            end else begin
               res >>= 1;
            end
            b >>= 2;
         end
         return res;
      endfunction

      // Work out the response of one accepted request and update the grid copy.
      function void note_request(wind_req_type t);
         longint       idx[3], frac[3], res[3], sum[3], hi[3];
         bit [63:0]    mag[3], s2, n;
         logic [31:0]  loc[3], vel[3];
         bit           over, st;
         int           a, k;
         wind_rsp_type e;
         loc = '{t.lx, t.ly, t.lz};
         vel = '{t.vx, t.vy, t.vz};
         res = '{0, 0, 0};
         st = ST_OK;
         for (int c = 0; c < 3; c++)
            to_grid(longint'(signed'(loc[c])) - ctr[c], idx[c], frac[c]);
         if (t.cmd == CMD_SAMPLE) begin
            // upper neighbor clamps to the last cell
            for (int c = 0; c < 3; c++)
               hi[c] = (idx[c] + 1 < EDGE - 1) ? idx[c] + 1 : EDGE - 1;
            for (int c = 0; c < 3; c++) begin
               longint p, q, r, s;
               p = blend(fetch(c, idx[0], idx[1], idx[2]), fetch(c, hi[0], idx[1], idx[2]),
                         frac[0]);
               q = blend(fetch(c, idx[0], hi[1], idx[2]), fetch(c, hi[0], hi[1], idx[2]),
                         frac[0]);
               r = blend(fetch(c, idx[0], idx[1], hi[2]), fetch(c, hi[0], idx[1], hi[2]),
                         frac[0]);
               s = blend(fetch(c, idx[0], hi[1], hi[2]), fetch(c, hi[0], hi[1], hi[2]),
                         frac[0]);
               res[c] = blend(blend(p, q, frac[1]), blend(r, s, frac[1]), frac[2]);
            end
         end else if (!on_grid(idx[0], idx[1], idx[2])) begin
            st = ST_OUTSIDE;
         end else begin
            a = int'(idx[0] + idx[1] * EDGE + idx[2] * EDGE * EDGE);
            sum[0] = longint'(cell_x[a]) + longint'(signed'(vel[0]));
            sum[1] = longint'(cell_y[a]) + longint'(signed'(vel[1]));
            sum[2] = longint'(cell_z[a]) + longint'(signed'(vel[2]));
            over = 0;
            for (int c = 0; c < 3; c++) begin
               mag[c] = (sum[c] < 0) ? 64'(-sum[c]) : 64'(sum[c]);
               if (mag[c] > speed_cap) over = 1;
            end
            if (!over) begin
               s2 = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
               if (s2 > speed_cap * speed_cap) over = 1;
            end
            if (over) begin
               // rescale onto the speed limit; narrow wide sums first
               k = (mag[0] >= 64'h8000_0000 || mag[1] >= 64'h8000_0000 ||
                    mag[2] >= 64'h8000_0000) ? 2 : 0;
               for (int c = 0; c < 3; c++) mag[c] >>= k;
               n = root64(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
               if (n == 0) n = 1;
               for (int c = 0; c < 3; c++) begin
                  longint v;
                  v = longint'((mag[c] * speed_cap) / n);
                  sum[c] = (sum[c] < 0) ? -v : v;
               end
            end
            cell_x[a] = int'(sum[0]);
            cell_y[a] = int'(sum[1]);
            cell_z[a] = int'(sum[2]);
            res = sum;
         end
         e.vx = res[0][31:0];
         e.vy = res[1][31:0];
         e.vz = res[2][31:0];
         e.st = st;
         pending_rsp.push_back(e);
      endfunction

      task report(string msg);
         errors++;
         $display("[%0t] mismatch: %s", $time, msg);
      endtask

      task check_response(wind_rsp_type got);
         wind_rsp_type e;
         if (pending_rsp.size() == 0) begin
            report("response with no request outstanding");
            return;
         end
         e = pending_rsp.pop_front();
         if (got.vx !== e.vx) report($sformatf("vel_x got %h exp %h", got.vx, e.vx));
         if (got.vy !== e.vy) report($sformatf("vel_y got %h exp %h", got.vy, e.vy));
         if (got.vz !== e.vz) report($sformatf("vel_z got %h exp %h", got.vz, e.vz));
         if (got.st !== e.st) report($sformatf("status got %b exp %b", got.st, e.st));
      endtask

      function int outstanding();
         return pending_rsp.size();
      endfunction
   endclass

   logic                 clock, reset, start, busy;
   logic                 rsp_valid, rsp_status;
   vel_type              rsp_vel_x, rsp_vel_y, rsp_vel_z;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [VEL_W-1:0]     csr_wdata;
   wind_req_type         cur;

   wind_scoreboard sb = new();

   // stimulus shaping for the current register setting
   longint    cen[3];
   longint    span;
   bit        no_gaps;

   wind_grid_sample_and_inject #(.GRID_EDGE(EDGE)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(cur.cmd), .req_loc_x(cur.lx), .req_loc_y(cur.ly), .req_loc_z(cur.lz),
      .req_add_vx(cur.vx), .req_add_vy(cur.vy), .req_add_vz(cur.vz),
      .rsp_valid(rsp_valid), .rsp_vel_x(rsp_vel_x), .rsp_vel_y(rsp_vel_y),
      .rsp_vel_z(rsp_vel_z), .rsp_status(rsp_status),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #40_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // Monitor: check the response first, since it belongs to an older transaction
   // than a request taken at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            sb.check_response('{rsp_vel_x, rsp_vel_y, rsp_vel_z, rsp_status});
         if (start && !busy)
            sb.note_request(cur);
      end
   end

   // Present one transaction and hold it until the block takes it.
   task send(wind_req_type t);
      @(negedge clock);
      cur = t;
      start = 1'b1;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
   endtask

   task idle(int n);
      repeat (n) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   // Drop start and wait for all outstanding responses plus a tail for in-flight work.
   task drain();
      int guard;
      idle(1);
      guard = 0;
      while (sb.outstanding() != 0 && guard < 100_000) begin
         @(posedge clock);
         guard++;
      end
      idle(SETTLE);
   endtask

   task csr_write(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(posedge clock);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task set_phase(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                  logic [31:0] inv, logic [31:0] ms);
      drain();
      csr_write(CSR_CENTER_X, cx);
      csr_write(CSR_CENTER_Y, cy);
      csr_write(CSR_CENTER_Z, cz);
      csr_write(CSR_INV_CELL, inv);
      csr_write(CSR_MAX_SPEED, ms);
      cen = '{longint'(signed'(cx)), longint'(signed'(cy)), longint'(signed'(cz))};
      // world distance that covers the grid plus a margin
      span = (inv == 0) ? (longint'(1) << 20) : (longint'(36) << 32) / longint'(inv);
      if (span > 64'sh7FFF_FFFF) span = 64'sh7FFF_FFFF;
      if (span < 4) span = 4;
   endtask

   function logic [31:0] pick_loc(int axis);
      int unsigned r;
      longint off;
      r = $urandom_range(0, 99);
      if (r < 10) return $urandom;
      // crowd half the traffic near the low corner so samples see earlier adds
      if (r < 60) off = longint'($urandom_range(0, int'(span / 8)));
      else off = longint'($urandom_range(0, int'(span + span / 8))) - span / 16;
      return 32'(cen[axis] + off);
   endfunction

   function logic [31:0] pick_vel();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 20) return $urandom;
      if (r < 40) return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
      return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
   endfunction

   function wind_req_type pick_req();
      wind_req_type t;
      t.cmd = ($urandom_range(0, 1) == 1) ? CMD_ADD : CMD_SAMPLE;
      t.lx = pick_loc(0);
      t.ly = pick_loc(1);
      t.lz = pick_loc(2);
      t.vx = pick_vel();
      t.vy = pick_vel();
      t.vz = pick_vel();
      return t;
   endfunction

   task random_run(int count);
      for (int i = 0; i < count; i++) begin
         // hold off until the block is empty once per setting
         if (i == count / 2) drain();
         send(pick_req());
         if (!(no_gaps && i < 200) && $urandom_range(0, 99) < 18)
            idle($urandom_range(1, 12));
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      cur = '0;
      csr_we = 1'b0;
      csr_index = CSR_CENTER_X;
      csr_wdata = '0;
      cen = '{0, 0, 0};
      span = longint'(36) << 16;
      no_gaps = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: reset setting, one cell per Q16.16 unit.
      send('{CMD_SAMPLE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
      send('{CMD_ADD, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
             32'h0001_8000, 32'hFFFD_C000, 32'h0003_0000});
      send('{CMD_SAMPLE, 32'h0000_8000, 32'h0001_8000, 32'h0000_C000, 0, 0, 0});
      send('{CMD_SAMPLE, 32'h0001_8000, 32'h0001_4000, 32'h0001_2000, 0, 0, 0});
      send('{CMD_ADD, 32'h001F_0000, 32'h001F_0000, 32'h001F_FFFF,
             32'h0100_0000, 32'hFF00_0000, 32'h0000_0001});
      send('{CMD_SAMPLE, 32'h001F_8000, 32'h001F_8000, 32'h001F_8000, 0, 0, 0});
      send('{CMD_SAMPLE, 32'hFFFF_8000, 32'hFFFF_8000, 32'hFFFF_8000, 0, 0, 0});
      send('{CMD_ADD, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0001_0000, 0, 0});
      send('{CMD_ADD, 32'h0020_0000, 32'h0, 32'h0, 32'h0001_0000, 0, 0});
      send('{CMD_ADD, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000,
             32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
      send('{CMD_ADD, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
      send('{CMD_ADD, 32'h0003_0000, 32'h0, 32'h0, 0, 0, 0});
      send('{CMD_SAMPLE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0});
      send('{CMD_SAMPLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0});
      send('{CMD_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 0, 0});
      send('{CMD_SAMPLE, 32'h0002_FFFF, 32'h0001_FFFF, 32'h0001_FFFF, 0, 0, 0});
      random_run(RAND_ITEMS);
      no_gaps = 1'b0;

      // Unknown register index must leave the setting alone.
      drain();
      csr_write(CSR_UNUSED, 32'hDEAD_BEEF);

      for (int p = 1; p < PHASES; p++) begin
         case (p)
            1: set_phase(32'h0, 32'h0, 32'h0, 32'h0002_0000, 32'h0002_0000);
            2: set_phase($urandom, $urandom, $urandom, 32'h0000_8000, 32'h7FFF_FFFF);
            3: set_phase(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0);
            4: set_phase(32'h7FFF_FFFF, 32'h8000_0000, $urandom, 32'hFFFF_FFFF,
                         {1'b0, 31'($urandom)});
            default: set_phase(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'd65536000);
         endcase
         if (p == 2) begin
            // two wide negative adds on one cell push the sum past 32 bits
            send('{CMD_ADD, 32'(cen[0] + (5 << 17)), 32'(cen[1] + (5 << 17)),
                   32'(cen[2] + (5 << 17)), 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
            send('{CMD_ADD, 32'(cen[0] + (5 << 17)), 32'(cen[1] + (5 << 17)),
                   32'(cen[2] + (5 << 17)), 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
         end
         random_run(RAND_ITEMS);
      end

      drain();
      if (sb.outstanding() != 0)
         sb.report($sformatf("%0d responses never arrived", sb.outstanding()));
      if (sb.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
